// ===== hdl/scan_disk_scheduler_core_macros.svh =====
// ----------------------------------------------------------------------------
// scan disk scheduler assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SCAN_DISK_SCHEDULER_CORE_MACROS_SVH
`define SCAN_DISK_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// shared constants, types and helpers of the scan disk scheduler
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MAX_REQ    = 32;
  localparam int TRACK_BITS = 16;
  localparam int TRACK_W    = TRACK_BITS;
  localparam int DISK_W     = 17;
  localparam int DIST_W     = 17;
  localparam int CFG_IDX_W  = 2;

  // set holds the requests plus head, outer end and track zero
  localparam int SET_MAX = MAX_REQ + 3;
  localparam int IDX_W   = $clog2(SET_MAX);
  localparam int N_W     = $clog2(SET_MAX + 1);
  localparam int CNT_W   = $clog2(MAX_REQ + 1);

  localparam logic [DISK_W-1:0] DISK_LIMIT = DISK_W'(1) << TRACK_BITS;
  localparam logic [DISK_W-1:0] DISK_MIN   = DISK_W'(2);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV_HEAD  = 2'd2;

  // fixed slots of the set store, requests follow
  localparam logic [IDX_W-1:0] SLOT_HEAD = IDX_W'(0);
  localparam logic [IDX_W-1:0] SLOT_END  = IDX_W'(1);
  localparam logic [IDX_W-1:0] SLOT_ZERO = IDX_W'(2);
  localparam logic [IDX_W-1:0] SLOT_REQ  = IDX_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_RANK,
    ST_HEAD,
    ST_EMIT,
    ST_DRAIN
  } sds_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic clamp_step;
    logic rank_step;
    logic emit_head;
    logic emit_step;
  } sds_cmd_t;

  typedef struct packed {
    logic clamp_last;
    logic rank_last;
    logic emit_last;
  } sds_status_t;

  function automatic logic [TRACK_W-1:0] outer_end(input logic [DISK_W-1:0] ds);
    logic [DISK_W-1:0] size;
    if (ds < DISK_MIN) begin
      size = DISK_MIN;
    end else if (ds > DISK_LIMIT) begin
      size = DISK_LIMIT;
    end else begin
      size = ds;
    end
    return TRACK_W'(size - DISK_W'(1));
  endfunction

  function automatic logic [TRACK_W-1:0] clamp_track(input logic [TRACK_W-1:0] t,
                                                     input logic [TRACK_W-1:0] e);
    return (t > e) ? e : t;
  endfunction

endpackage

// ===== hdl/sds_ctrl.sv =====
// ----------------------------------------------------------------------------
// sds_ctrl
// sequencer: load, clamp pass, rank pass, head result, service order emit
// ----------------------------------------------------------------------------
module sds_ctrl import sds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        in_req_last,
  input  sds_status_t status,
  output sds_cmd_t    cmd,
  output logic        busy
);

  sds_state_t state_r;
  sds_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && in_req_last) begin
          cmd.init  = 1'b1;
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp_step = 1'b1;
        if (status.clamp_last) begin
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (status.rank_last) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.emit_head = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sds_datapath.sv =====
// ----------------------------------------------------------------------------
// sds_datapath
// config registers, set store, rank sort into sorted store, seek accumulation
// ----------------------------------------------------------------------------
module sds_datapath import sds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sds_cmd_t             cmd,
  output sds_status_t          status,
  input  logic [TRACK_W-1:0]   in_req_track,
  input  logic                 in_req_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DISK_W-1:0]    cfg_data,
  output logic                 out_valid,
  output logic [TRACK_W-1:0]   out_seek_track,
  output logic [DIST_W-1:0]    out_total_distance,
  output logic                 out_seq_last
);

  logic [DISK_W-1:0]  disk_size_r;
  logic [TRACK_W-1:0] start_head_r;
  logic [TRACK_W-1:0] prev_head_r;

  logic [CNT_W-1:0]   cnt_r;
  logic [N_W-1:0]     n_r;
  logic [TRACK_W-1:0] end_r;
  logic [TRACK_W-1:0] head_r;
  logic               up_r;
  logic [IDX_W-1:0]   i_r;
  logic [IDX_W-1:0]   j_r;

  logic [TRACK_W-1:0] set_mem [SET_MAX];
  logic [TRACK_W-1:0] sorted_mem [SET_MAX];
  logic [TRACK_W-1:0] rd_a_r;
  logic [TRACK_W-1:0] rd_b_r;
  logic [TRACK_W-1:0] sd_r;

  logic               cl_v_r;
  logic [IDX_W-1:0]   cl_idx_r;
  logic               rk_v_r;
  logic [IDX_W-1:0]   rk_i_r;
  logic [IDX_W-1:0]   rk_j_r;
  logic [IDX_W-1:0]   acc_r;
  logic [IDX_W-1:0]   split_r;
  logic               em_v_r;
  logic               em_last_r;
  logic               head_v_r;

  logic               out_valid_r;
  logic [TRACK_W-1:0] out_seek_r;
  logic [DIST_W-1:0]  out_total_r;
  logic               out_last_r;

  logic               room;
  logic [CNT_W-1:0]   cnt_after;
  logic               load_we;
  logic [IDX_W-1:0]   load_addr;
  logic [TRACK_W-1:0] head_c;
  logic [TRACK_W-1:0] cl_val;
  logic               set_we;
  logic [IDX_W-1:0]   set_waddr;
  logic [TRACK_W-1:0] set_wdata;
  logic [IDX_W-1:0]   last_idx;
  logic               lt;
  logic [IDX_W-1:0]   rank_sum;
  logic               rk_end;
  logic [IDX_W-1:0]   up_cnt;
  logic [IDX_W-1:0]   em_addr;
  logic [TRACK_W-1:0] diff;
  logic [DIST_W-1:0]  total_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_size_r  <= DISK_W'(200);
      start_head_r <= '0;
      prev_head_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISK_SIZE:  disk_size_r  <= cfg_data;
        CFG_START_HEAD: start_head_r <= cfg_data[TRACK_W-1:0];
        CFG_PREV_HEAD:  prev_head_r  <= cfg_data[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  assign room      = cnt_r < CNT_W'(MAX_REQ);
  assign cnt_after = room ? cnt_r + CNT_W'(1) : cnt_r;
  assign load_we   = cmd.load && room;
  assign load_addr = IDX_W'(cnt_r) + SLOT_REQ;
  assign last_idx  = IDX_W'(n_r - N_W'(1));
  assign head_c    = clamp_track(start_head_r, end_r);

  assign status.clamp_last = (i_r == last_idx);
  assign status.rank_last  = (i_r == last_idx) && (j_r == last_idx);
  assign status.emit_last  = (j_r == IDX_W'(n_r - N_W'(3)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= in_req_last ? '0 : cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      n_r   <= N_W'(cnt_after) + N_W'(3);
      end_r <= outer_end(disk_size_r);
    end
    if (cmd.clamp_step && (i_r == SLOT_HEAD)) begin
      head_r <= head_c;
      up_r   <= prev_head_r < head_c;
    end
  end

  // walk counters: i is the set index, j the inner rank index or emit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.init) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.clamp_step) begin
      i_r <= status.clamp_last ? '0 : i_r + IDX_W'(1);
    end else if (cmd.rank_step) begin
      if (j_r == last_idx) begin
        j_r <= '0;
        i_r <= status.rank_last ? '0 : i_r + IDX_W'(1);
      end else begin
        j_r <= j_r + IDX_W'(1);
      end
    end else if (cmd.emit_step) begin
      j_r <= j_r + IDX_W'(1);
    end
  end

  // clamp pass write value per slot
  always_comb begin
    priority if (cl_idx_r == SLOT_HEAD) begin
      cl_val = head_r;
    end else if (cl_idx_r == SLOT_END) begin
      cl_val = end_r;
    end else if (cl_idx_r == SLOT_ZERO) begin
      cl_val = '0;
    end else begin
      cl_val = clamp_track(rd_a_r, end_r);
    end
  end

  assign set_we    = load_we || cl_v_r;
  assign set_waddr = cl_v_r ? cl_idx_r : load_addr;
  assign set_wdata = cl_v_r ? cl_val : in_req_track;

  always_ff @(posedge clk) begin
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    rd_a_r <= set_mem[i_r];
    rd_b_r <= set_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_v_r   <= 1'b0;
      rk_v_r   <= 1'b0;
      em_v_r   <= 1'b0;
      head_v_r <= 1'b0;
    end else begin
      cl_v_r   <= cmd.clamp_step;
      rk_v_r   <= cmd.rank_step;
      em_v_r   <= cmd.emit_step;
      head_v_r <= cmd.emit_head;
    end
  end

  always_ff @(posedge clk) begin
    cl_idx_r  <= i_r;
    rk_i_r    <= i_r;
    rk_j_r    <= j_r;
    em_last_r <= status.emit_last;
  end

  // stable rank: ties go by set index, so the head slot leads its equals
  assign lt       = (rd_b_r < rd_a_r) || ((rd_b_r == rd_a_r) && (rk_j_r < rk_i_r));
  assign rank_sum = ((rk_j_r == '0) ? '0 : acc_r) + IDX_W'(lt);
  assign rk_end   = (rk_j_r == last_idx);

  always_ff @(posedge clk) begin
    if (rk_v_r) begin
      acc_r <= rank_sum;
      if (rk_end && (rk_i_r == SLOT_HEAD)) begin
        split_r <= rank_sum;
      end
    end
  end

  // service order address from emit count j
  assign up_cnt = last_idx - split_r;
  always_comb begin
    if (up_r) begin
      em_addr = (j_r < up_cnt) ? split_r + IDX_W'(1) + j_r : last_idx - IDX_W'(1) - j_r;
    end else begin
      em_addr = (j_r < split_r) ? split_r - IDX_W'(1) - j_r : j_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rk_v_r && rk_end) begin
      sorted_mem[rank_sum] <= rd_a_r;
    end
    sd_r <= sorted_mem[em_addr];
  end

  // seek accumulation, result register doubles as head position and total
  assign diff      = (sd_r > out_seek_r) ? sd_r - out_seek_r : out_seek_r - sd_r;
  assign total_nxt = out_total_r + DIST_W'(diff);

  // head result is registered through head_v_r so it lines up with the sorted reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= head_v_r || em_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_v_r) begin
      out_seek_r  <= head_r;
      out_total_r <= '0;
      out_last_r  <= 1'b0;
    end else if (em_v_r) begin
      out_seek_r  <= sd_r;
      out_total_r <= total_nxt;
      out_last_r  <= em_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_seek_track     = out_seek_r;
  assign out_total_distance = out_total_r;
  assign out_seq_last       = out_last_r;

endmodule

// ===== hdl/scan_disk_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// scan_disk_scheduler_core
// scan (elevator) disk scheduler: loads requests, emits the service order
// ----------------------------------------------------------------------------
// Requests load one per cycle while busy is low (start high, busy low); up to
// MAX_REQ are kept and later ones are dropped. The item with in_req_last high
// is stored too and starts a schedule over n = stored requests + 3 entries
// (start head, outer end, track zero). Busy then stays high while a pass clamps
// the set to the disk, a rank sort reads every pair of set entries through the
// set store's two read ports one pair per cycle, the head is issued, the sorted
// store is read one entry per cycle and the pipeline drains.
// The n-1 results (start head first) come on consecutive cycles, each strobed
// by out_valid for one cycle only; the receiver cannot stall them and must
// take each one as it comes. The last result, marked by out_seq_last, shows
// in the first cycle that busy is low again. cfg_ready is always high; write
// configuration only while the block is idle.
module scan_disk_scheduler_core import sds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [TRACK_W-1:0]   in_req_track,
  input  logic                 in_req_last,
  output logic                 out_valid,
  output logic [TRACK_W-1:0]   out_seek_track,
  output logic [DIST_W-1:0]    out_total_distance,
  output logic                 out_seq_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DISK_W-1:0]    cfg_data
);

  sds_cmd_t    cmd;
  sds_status_t status;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  sds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_last (in_req_last),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  sds_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_req_track       (in_req_track),
    .in_req_last        (in_req_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_seek_track     (out_seek_track),
    .out_total_distance (out_total_distance),
    .out_seq_last       (out_seq_last)
  );

endmodule

// ===== hdl/sds_checker.sv =====
// ----------------------------------------------------------------------------
// sds_checker
// port-level checks of the scan disk scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "scan_disk_scheduler_core_macros.svh"

module sds_checker import sds_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_req_last,
  input logic              out_valid,
  input logic [DIST_W-1:0] out_total_distance,
  input logic              out_seq_last
);

  // a last item always opens a schedule
  `SDS_ASSERT_NEXT(a_last_starts_run, start && !busy && in_req_last, busy, "schedule did not start")

  // results of a run come back to back until the final one
  `SDS_ASSERT_NEXT(a_stream_contiguous, out_valid && !out_seq_last, out_valid, "gap in result stream")

  // nothing follows the final result directly
  `SDS_ASSERT_NEXT(a_no_extra_result, out_valid && out_seq_last, !out_valid, "result after final item")

  // only the final result may show while idle
  `SDS_ASSERT_NOW(a_busy_during_run, out_valid && !out_seq_last, busy, "result while idle")

  // the first result is the start head with no distance yet
  `SDS_ASSERT_NOW(a_head_zero, out_valid && !$past(out_valid), out_total_distance == '0, "head distance not zero")

endmodule

bind scan_disk_scheduler_core sds_checker u_sds_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_req_last        (in_req_last),
  .out_valid          (out_valid),
  .out_total_distance (out_total_distance),
  .out_seq_last       (out_seq_last)
);

// ===== tb/scan_disk_scheduler_core_test.sv =====
// ----------------------------------------------------------------------------
// scan_disk_scheduler_core_test
// feeds request batches under changing disk and head settings and checks each
// service-order result against typed values or a behavioral prediction of the sweep
// ----------------------------------------------------------------------------
module scan_disk_scheduler_core_test;
  import sds_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 4;
  localparam int RAND_ITEMS = 260;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 64;
  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam int DIR_ROWS = 35;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  // one directed step: a register write or a request item, with the three
  // results of a single-request batch typed in where typed is set
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DISK_W-1:0]     value;
    logic                  last;
    logic                  typed;
    logic [TRACK_W-1:0]    t0;
    logic [TRACK_W-1:0]    t1;
    logic [DIST_W-1:0]     d1;
    logic [TRACK_W-1:0]    t2;
    logic [DIST_W-1:0]     d2;
  } row_t;

  typedef struct {
    logic [TRACK_W-1:0] track;
    logic [DIST_W-1:0]  distance;
    logic               last;
  } seek_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [TRACK_W-1:0]   in_req_track = '0;
  logic                 in_req_last = 1'b0;
  logic                 out_valid;
  logic [TRACK_W-1:0]   out_seek_track;
  logic [DIST_W-1:0]    out_total_distance;
  logic                 out_seq_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DISK_W-1:0]    cfg_data = '0;

  // scheduler state as the block should hold it
  logic [DISK_W-1:0]  disk_reg = 17'd200;
  logic [TRACK_W-1:0] head_reg = '0;
  logic [TRACK_W-1:0] prev_reg = '0;
  logic [TRACK_W-1:0] pending[$];
  seek_t              sweep_plan[$];
  seek_t              seek_q[$];

  int idle_pct = 15;
  int items_sent = 0;
  int schedules = 0;
  int results = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int overflows = 0;

  row_t dir_rows [DIR_ROWS] = '{
    // after reset: disk 200, head 0, prev 0, so the sweep goes down
    '{ROW_REQ, '0, 17'd50,    1'b1, 1'b1, 16'd0,   16'd0,    17'd0,     16'd50,  17'd50},
    '{ROW_REQ, '0, 17'd65535, 1'b1, 1'b1, 16'd0,   16'd0,    17'd0,     16'd199, 17'd199},
    '{ROW_CFG, CFG_START_HEAD, 17'd100, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd150,   1'b1, 1'b1, 16'd100, 16'd150,  17'd50,    16'd199, 17'd99},
    '{ROW_REQ, '0, 17'd20,    1'b1, 1'b1, 16'd100, 16'd199,  17'd99,    16'd20,  17'd278},
    '{ROW_CFG, CFG_PREV_HEAD, 17'd200, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd150,   1'b1, 1'b1, 16'd100, 16'd0,    17'd100,   16'd150, 17'd250},
    '{ROW_REQ, '0, 17'd100,   1'b1, 1'b0, '0, '0, '0, '0, '0},
    // size below two acts as two, head clamps to the outer end
    '{ROW_CFG, CFG_DISK_SIZE, 17'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd0,     1'b1, 1'b1, 16'd1,   16'd0,    17'd1,     16'd0,   17'd1},
    '{ROW_CFG, CFG_DISK_SIZE, 17'd131071, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_START_HEAD, 17'd1, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_PREV_HEAD, 17'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    // full sweep up and back, largest distance
    '{ROW_REQ, '0, 17'd0,     1'b1, 1'b1, 16'd1,   16'd65535, 17'd65534, 16'd0,  17'd131069},
    '{ROW_CFG, CFG_SPARE, 17'd131071, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd65535, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_DISK_SIZE, 17'd65536, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_START_HEAD, 17'd32768, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_PREV_HEAD, 17'd32768, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd40000, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd32768, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd100,   1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd65535, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_PREV_HEAD, 17'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd5,     1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd60000, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd32768, 1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_DISK_SIZE, 17'd2, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_START_HEAD, 17'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd1,     1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd0,     1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd65535, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd1,     1'b1, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_CFG, CFG_START_HEAD, 17'd65535, 1'b0, 1'b0, '0, '0, '0, '0, '0},
    '{ROW_REQ, '0, 17'd0,     1'b1, 1'b0, '0, '0, '0, '0, '0}
  };

  scan_disk_scheduler_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_track       (in_req_track),
    .in_req_last        (in_req_last),
    .out_valid          (out_valid),
    .out_seek_track     (out_seek_track),
    .out_total_distance (out_total_distance),
    .out_seq_last       (out_seq_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic int unsigned track_end();
    int unsigned size;
    size = disk_reg;
    if (size < 2) size = 2;
    if (size > (1 << TRACK_BITS)) size = 1 << TRACK_BITS;
    return size - 1;
  endfunction

  // store one request; on the last item build the elevator service order
  function automatic void predict_sweep(input logic [TRACK_W-1:0] track, input logic last);
    int unsigned ent [SET_MAX];
    int unsigned route[$];
    int unsigned n, i, j, v, split, head, outer, pos, diff;
    logic [DIST_W-1:0] total;
    sweep_plan.delete();
    if (pending.size() < MAX_REQ) pending.push_back(track);
    if (!last) return;
    schedules++;
    outer = track_end();
    head = head_reg;
    if (head > outer) head = outer;
    n = 0;
    foreach (pending[k]) begin
      ent[n] = (pending[k] > outer) ? outer : pending[k];
      n++;
    end
    ent[n] = head;
    ent[n + 1] = outer;
    ent[n + 2] = 0;
    n += 3;
    pending.delete();
    for (i = 1; i < n; i++) begin
      v = ent[i];
      j = i;
      while (j > 0 && ent[j - 1] > v) begin
        ent[j] = ent[j - 1];
        j--;
      end
      ent[j] = v;
    end
    // lower side ends before the first copy of the head
    split = 0;
    while (split < n && ent[split] != head) split++;
    if (prev_reg < head) begin
      for (i = split + 1; i < n; i++) route.push_back(ent[i]);
      for (i = split; i > 1; i--) route.push_back(ent[i - 1]);
    end else begin
      for (i = split; i > 0; i--) route.push_back(ent[i - 1]);
      for (i = split + 1; i + 1 < n; i++) route.push_back(ent[i]);
    end
    pos = head;
    total = '0;
    sweep_plan.push_back('{TRACK_W'(head), '0, route.size() == 0});
    foreach (route[k]) begin
      diff = (route[k] > pos) ? route[k] - pos : pos - route[k];
      total = DIST_W'(total + diff);
      pos = route[k];
      sweep_plan.push_back('{TRACK_W'(pos), total, k == route.size() - 1});
    end
  endfunction

  task automatic send_item(input logic [TRACK_W-1:0] track, input logic last);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_track <= track;
    in_req_last <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic issue(input logic [TRACK_W-1:0] track, input logic last);
    send_item(track, last);
    predict_sweep(track, last);
    foreach (sweep_plan[k]) seek_q.push_back(sweep_plan[k]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DISK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DISK_SIZE:  disk_reg = value;
      CFG_START_HEAD: head_reg = value[TRACK_W-1:0];
      CFG_PREV_HEAD:  prev_reg = value[TRACK_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // hold the sender until every expected result has come, then settle
  task automatic wait_idle(input int settle);
    start <= 1'b0;
    do @(posedge clk); while (seek_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    seek_t want;
    if (rst_n && out_valid) begin
      if (seek_q.size() == 0) begin
        $error("result with nothing expected: seek_track %0d", out_seek_track);
        mismatches++;
      end else begin
        want = seek_q.pop_front();
        results++;
        if (out_seek_track !== want.track) begin
          $error("seek_track expected %0d got %0d", want.track, out_seek_track);
          mismatches++;
        end
        if (out_total_distance !== want.distance) begin
          $error("total_distance expected %0d got %0d", want.distance, out_total_distance);
          mismatches++;
        end
        if (out_seq_last !== want.last) begin
          $error("seq_last expected %0d got %0d", want.last, out_seq_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t               row;
    int                 rand_items;
    int                 sets_left;
    int                 len;
    int unsigned        outer;
    logic [DISK_W-1:0]  dsize;
    logic [TRACK_W-1:0] hd;
    logic [TRACK_W-1:0] pv;
    logic [TRACK_W-1:0] trk;
    rand_items = 0;
    sets_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        if (!cfg_valid) wait_idle(CFG_SETTLE);
        write_reg(row.idx, row.value);
      end else if (row.typed) begin
        send_item(row.value[TRACK_W-1:0], row.last);
        predict_sweep(row.value[TRACK_W-1:0], row.last);
        seek_q.push_back('{row.t0, '0, 1'b0});
        seek_q.push_back('{row.t1, row.d1, 1'b0});
        seek_q.push_back('{row.t2, row.d2, 1'b1});
      end else begin
        issue(row.value[TRACK_W-1:0], row.last);
      end
    end

    while (rand_items < RAND_ITEMS) begin
      if (sets_left == 0) begin
        wait_idle(CFG_SETTLE);
        case ($urandom_range(7))
          0:       dsize = DISK_W'($urandom_range(1));
          1:       dsize = DISK_MIN;
          2:       dsize = DISK_LIMIT;
          3:       dsize = DISK_W'($urandom_range(131071, 65537));
          4:       dsize = DISK_W'($urandom_range(131071));
          default: dsize = DISK_W'($urandom_range(400, 2));
        endcase
        write_reg(CFG_DISK_SIZE, dsize);
        outer = track_end();
        case ($urandom_range(5))
          0:       hd = '0;
          1:       hd = '1;
          2:       hd = TRACK_W'(outer);
          3:       hd = TRACK_W'($urandom);
          default: hd = TRACK_W'($urandom_range(outer));
        endcase
        write_reg(CFG_START_HEAD, DISK_W'(hd));
        case ($urandom_range(6))
          0:       pv = hd;
          1:       pv = hd + 1'b1;
          2:       pv = hd - 1'b1;
          3:       pv = TRACK_W'($urandom);
          4:       pv = '0;
          5:       pv = '1;
          default: pv = TRACK_W'($urandom_range(outer));
        endcase
        write_reg(CFG_PREV_HEAD, DISK_W'(pv));
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE, DISK_W'($urandom));
        sets_left = $urandom_range(6, 2);
      end
      // first batch overruns the store; later ones are mostly short
      if (rand_items == 0) begin
        len = MAX_REQ + 4;
      end else begin
        case ($urandom_range(99) / 10)
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(5, 1);
          7, 8:                len = $urandom_range(16, 6);
          default:             len = $urandom_range(MAX_REQ + 6, MAX_REQ - 2);
        endcase
      end
      if (len > MAX_REQ) overflows++;
      outer = track_end();
      for (int b = 0; b < len; b++) begin
        case ($urandom_range(7))
          0:       trk = '0;
          1:       trk = TRACK_W'(outer);
          2:       trk = head_reg;
          3, 4:    trk = TRACK_W'($urandom);
          default: trk = TRACK_W'($urandom_range(outer));
        endcase
        issue(trk, b == len - 1);
        rand_items++;
        if (rand_items < RAND_ITEMS / 3) idle_pct = 15;
        else if (rand_items < 2 * RAND_ITEMS / 3) idle_pct = 66;
        else idle_pct = 0;
      end
      sets_left--;
      if ($urandom_range(7) == 0) wait_idle(0);
    end

    wait_idle(END_SETTLE);
    $display("checked %0d results from %0d schedules over %0d request items",
             results, schedules, items_sent);
    $display("%0d register writes, %0d batches overran the %0d-entry store",
             reg_writes, overflows, MAX_REQ);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout with %0d results outstanding", seek_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sds_pkg.sv
hdl/sds_ctrl.sv
hdl/sds_datapath.sv
hdl/scan_disk_scheduler_core.sv
hdl/sds_checker.sv
tb/scan_disk_scheduler_core_test.sv
